/* design/seg_pkg.sv */
// Shared constants and types for the segment intersection test pipeline.
// Point and difference indexes, operand tables and the stage-3 flag bundle.
// No dependencies.
package seg_pkg;

  localparam int unsigned NumPt   = 4;
  localparam int unsigned NumDiff = 10;

  // point indexes
  localparam int unsigned PtA = 0;
  localparam int unsigned PtB = 1;
  localparam int unsigned PtC = 2;
  localparam int unsigned PtD = 3;

  // difference indexes: name is minuend then subtrahend
  localparam int unsigned DiffBA = 0;
  localparam int unsigned DiffCA = 1;
  localparam int unsigned DiffDA = 2;
  localparam int unsigned DiffDC = 3;
  localparam int unsigned DiffAC = 4;
  localparam int unsigned DiffBC = 5;
  localparam int unsigned DiffAD = 6;
  localparam int unsigned DiffBD = 7;
  localparam int unsigned DiffCB = 8;
  localparam int unsigned DiffDB = 9;

  localparam int unsigned DiffHi [NumDiff] = '{PtB, PtC, PtD, PtD, PtA,
                                               PtB, PtA, PtB, PtC, PtD};
  localparam int unsigned DiffLo [NumDiff] = '{PtA, PtA, PtA, PtC, PtC,
                                               PtC, PtD, PtD, PtB, PtB};

  // per point: orientation of the point against the other segment
  localparam int unsigned OrU [NumPt] = '{DiffDC, DiffDC, DiffBA, DiffBA};
  localparam int unsigned OrV [NumPt] = '{DiffAC, DiffBC, DiffCA, DiffDA};

  // per point: dot of vectors from the point to the other segment's ends
  localparam int unsigned DotU [NumPt] = '{DiffCA, DiffCB, DiffAC, DiffAD};
  localparam int unsigned DotV [NumPt] = '{DiffDA, DiffDB, DiffBC, DiffBD};

  typedef struct packed {
    logic [NumPt-1:0] or_zero;
    logic [NumPt-1:0] or_neg;
    logic [NumPt-1:0] dot_le;
  } seg_flags_t;

endpackage

/* design/seg_diff.sv */
// Stage 1: coordinate differences between endpoints.
// Depends on seg_pkg for point and difference tables.
module seg_diff #(
  parameter int unsigned COORD_WIDTH = 30
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic signed [COORD_WIDTH-1:0] px_i [seg_pkg::NumPt],
  input  logic signed [COORD_WIDTH-1:0] py_i [seg_pkg::NumPt],
  output logic                          valid_o,
  output logic signed [COORD_WIDTH:0]   dx_o [seg_pkg::NumDiff],
  output logic signed [COORD_WIDTH:0]   dy_o [seg_pkg::NumDiff]
);
  import seg_pkg::*;

  localparam int unsigned DW = COORD_WIDTH + 1;

  logic              valid_q;
  logic signed [DW-1:0] dx_d [NumDiff];
  logic signed [DW-1:0] dy_d [NumDiff];
  logic signed [DW-1:0] dx_q [NumDiff];
  logic signed [DW-1:0] dy_q [NumDiff];

  always_comb begin
    for (int k = 0; k < NumDiff; k++) begin
      dx_d[k] = DW'(px_i[DiffHi[k]]) - DW'(px_i[DiffLo[k]]);
      dy_d[k] = DW'(py_i[DiffHi[k]]) - DW'(py_i[DiffLo[k]]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q <= dx_d;
    dy_q <= dy_d;
  end

  assign valid_o = valid_q;
  assign dx_o    = dx_q;
  assign dy_o    = dy_q;

endmodule

/* design/seg_mul.sv */
// Stage 2: partial products of the cross and dot terms.
// Depends on seg_pkg for the operand tables.
module seg_mul #(
  parameter int unsigned COORD_WIDTH = 30
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic signed [COORD_WIDTH:0]       dx_i [seg_pkg::NumDiff],
  input  logic signed [COORD_WIDTH:0]       dy_i [seg_pkg::NumDiff],
  output logic                              valid_o,
  output logic signed [2*COORD_WIDTH+1:0]   or_p0_o [seg_pkg::NumPt],
  output logic signed [2*COORD_WIDTH+1:0]   or_p1_o [seg_pkg::NumPt],
  output logic signed [2*COORD_WIDTH+1:0]   dot_p0_o [seg_pkg::NumPt],
  output logic signed [2*COORD_WIDTH+1:0]   dot_p1_o [seg_pkg::NumPt]
);
  import seg_pkg::*;

  localparam int unsigned PW = 2 * COORD_WIDTH + 2;

  logic                 valid_q;
  logic signed [PW-1:0] or_p0_d [NumPt];
  logic signed [PW-1:0] or_p1_d [NumPt];
  logic signed [PW-1:0] dot_p0_d [NumPt];
  logic signed [PW-1:0] dot_p1_d [NumPt];
  logic signed [PW-1:0] or_p0_q [NumPt];
  logic signed [PW-1:0] or_p1_q [NumPt];
  logic signed [PW-1:0] dot_p0_q [NumPt];
  logic signed [PW-1:0] dot_p1_q [NumPt];

  // cross: ux*vy - uy*vx, dot: ux*vx + uy*vy
  always_comb begin
    for (int k = 0; k < NumPt; k++) begin
      or_p0_d[k]  = PW'(dx_i[OrU[k]]) * PW'(dy_i[OrV[k]]);
      or_p1_d[k]  = PW'(dy_i[OrU[k]]) * PW'(dx_i[OrV[k]]);
      dot_p0_d[k] = PW'(dx_i[DotU[k]]) * PW'(dx_i[DotV[k]]);
      dot_p1_d[k] = PW'(dy_i[DotU[k]]) * PW'(dy_i[DotV[k]]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    or_p0_q  <= or_p0_d;
    or_p1_q  <= or_p1_d;
    dot_p0_q <= dot_p0_d;
    dot_p1_q <= dot_p1_d;
  end

  assign valid_o  = valid_q;
  assign or_p0_o  = or_p0_q;
  assign or_p1_o  = or_p1_q;
  assign dot_p0_o = dot_p0_q;
  assign dot_p1_o = dot_p1_q;

endmodule

/* design/seg_flag.sv */
// Stage 3: sums of the partial products reduced to sign and zero flags.
// Depends on seg_pkg for the flag bundle.
module seg_flag #(
  parameter int unsigned COORD_WIDTH = 30
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  logic signed [2*COORD_WIDTH+1:0] or_p0_i [seg_pkg::NumPt],
  input  logic signed [2*COORD_WIDTH+1:0] or_p1_i [seg_pkg::NumPt],
  input  logic signed [2*COORD_WIDTH+1:0] dot_p0_i [seg_pkg::NumPt],
  input  logic signed [2*COORD_WIDTH+1:0] dot_p1_i [seg_pkg::NumPt],
  output logic                            valid_o,
  output seg_pkg::seg_flags_t             flags_o
);
  import seg_pkg::*;

  localparam int unsigned SW = 2 * COORD_WIDTH + 3;

  logic                 valid_q;
  logic signed [SW-1:0] or_s  [NumPt];
  logic signed [SW-1:0] dot_s [NumPt];
  seg_flags_t           flags_d;
  seg_flags_t           flags_q;

  always_comb begin
    for (int k = 0; k < NumPt; k++) begin
      or_s[k]  = SW'(or_p0_i[k]) - SW'(or_p1_i[k]);
      dot_s[k] = SW'(dot_p0_i[k]) + SW'(dot_p1_i[k]);
      flags_d.or_zero[k] = (or_s[k] == '0);
      flags_d.or_neg[k]  = or_s[k][SW-1];
      flags_d.dot_le[k]  = dot_s[k][SW-1] || (dot_s[k] == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    flags_q <= flags_d;
  end

  assign valid_o = valid_q;
  assign flags_o = flags_q;

endmodule

/* design/seg_decide.sv */
// Stage 4: side tests and collinear overlap decision, registered result.
// Depends on seg_pkg for point indexes and the flag bundle.
module seg_decide (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  seg_pkg::seg_flags_t flags_i,
  output logic                done_o,
  output logic                intersects_o
);
  import seg_pkg::*;

  logic             done_q;
  logic             hit_d;
  logic             hit_q;
  logic             side1_pos;
  logic             side2_pos;
  logic             side1_zero;
  logic             side2_zero;
  logic [NumPt-1:0] on_seg;

  always_comb begin
    side1_pos  = !flags_i.or_zero[PtC] && !flags_i.or_zero[PtD] &&
                 (flags_i.or_neg[PtC] == flags_i.or_neg[PtD]);
    side2_pos  = !flags_i.or_zero[PtA] && !flags_i.or_zero[PtB] &&
                 (flags_i.or_neg[PtA] == flags_i.or_neg[PtB]);
    side1_zero = flags_i.or_zero[PtC] || flags_i.or_zero[PtD];
    side2_zero = flags_i.or_zero[PtA] || flags_i.or_zero[PtB];
    on_seg     = flags_i.or_zero & flags_i.dot_le;
    if (side1_pos || side2_pos) begin
      hit_d = 1'b0;
    end else if (side1_zero && side2_zero) begin
      hit_d = |on_seg;
    end else begin
      hit_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q <= hit_d;
  end

  assign done_o       = done_q;
  assign intersects_o = hit_q;

endmodule

/* design/segment_intersection_test.sv */
// Closed segment intersection test: four-stage pipeline.
// A request passes the seg_diff, seg_mul, seg_flag and seg_decide registers before done_o.
// Throughput: one request per cycle; each stage holds one item.
// busy_o is held low; the result receiver cannot stall the pipeline.
// Reset clears only the valid bits of the stages; data registers are not reset.
// Depends on seg_pkg, seg_diff, seg_mul, seg_flag and seg_decide.
module segment_intersection_test #(
  parameter int unsigned COORD_WIDTH = 30
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [COORD_WIDTH-1:0] ax_i,
  input  logic signed [COORD_WIDTH-1:0] ay_i,
  input  logic signed [COORD_WIDTH-1:0] bx_i,
  input  logic signed [COORD_WIDTH-1:0] by_i,
  input  logic signed [COORD_WIDTH-1:0] cx_i,
  input  logic signed [COORD_WIDTH-1:0] cy_i,
  input  logic signed [COORD_WIDTH-1:0] qx_i,
  input  logic signed [COORD_WIDTH-1:0] qy_i,
  output logic                          done_o,
  output logic                          intersects_o
);
  import seg_pkg::*;

  localparam int unsigned DW = COORD_WIDTH + 1;
  localparam int unsigned PW = 2 * COORD_WIDTH + 2;

  logic signed [COORD_WIDTH-1:0] px [NumPt];
  logic signed [COORD_WIDTH-1:0] py [NumPt];
  logic                          req;
  logic                          s1_valid;
  logic                          s2_valid;
  logic                          s3_valid;
  logic signed [DW-1:0]          dx [NumDiff];
  logic signed [DW-1:0]          dy [NumDiff];
  logic signed [PW-1:0]          or_p0 [NumPt];
  logic signed [PW-1:0]          or_p1 [NumPt];
  logic signed [PW-1:0]          dot_p0 [NumPt];
  logic signed [PW-1:0]          dot_p1 [NumPt];
  seg_flags_t                    flags;

  assign busy_o = 1'b0;
  assign req    = start_i && !busy_o;

  always_comb begin
    px[PtA] = ax_i;
    py[PtA] = ay_i;
    px[PtB] = bx_i;
    py[PtB] = by_i;
    px[PtC] = cx_i;
    py[PtC] = cy_i;
    px[PtD] = qx_i;
    py[PtD] = qy_i;
  end

  seg_diff #(.COORD_WIDTH(COORD_WIDTH)) u_diff (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (req),
    .px_i    (px),
    .py_i    (py),
    .valid_o (s1_valid),
    .dx_o    (dx),
    .dy_o    (dy)
  );

  seg_mul #(.COORD_WIDTH(COORD_WIDTH)) u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s1_valid),
    .dx_i     (dx),
    .dy_i     (dy),
    .valid_o  (s2_valid),
    .or_p0_o  (or_p0),
    .or_p1_o  (or_p1),
    .dot_p0_o (dot_p0),
    .dot_p1_o (dot_p1)
  );

  seg_flag #(.COORD_WIDTH(COORD_WIDTH)) u_flag (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s2_valid),
    .or_p0_i  (or_p0),
    .or_p1_i  (or_p1),
    .dot_p0_i (dot_p0),
    .dot_p1_i (dot_p1),
    .valid_o  (s3_valid),
    .flags_o  (flags)
  );

  seg_decide u_decide (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s3_valid),
    .flags_i      (flags),
    .done_o       (done_o),
    .intersects_o (intersects_o)
  );

endmodule

/* design/seg_chk.sv */
// Port-level checks for segment_intersection_test, bound to the top level.
// Depends only on the top level's ports.
module seg_chk #(
  parameter int unsigned COORD_WIDTH = 30
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_o,
  input logic signed [COORD_WIDTH-1:0] ax_i,
  input logic signed [COORD_WIDTH-1:0] ay_i,
  input logic signed [COORD_WIDTH-1:0] bx_i,
  input logic signed [COORD_WIDTH-1:0] by_i,
  input logic signed [COORD_WIDTH-1:0] cx_i,
  input logic signed [COORD_WIDTH-1:0] cy_i,
  input logic signed [COORD_WIDTH-1:0] qx_i,
  input logic signed [COORD_WIDTH-1:0] qy_i,
  input logic                          done_o,
  input logic                          intersects_o
);

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o == 1'b0)
    else $error("busy_o raised");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##4 done_o)
    else $error("request without result four cycles later");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, 4))
    else $error("result strobe without matching request");

  a_same_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && ax_i == bx_i && ay_i == by_i && ax_i == cx_i &&
    ay_i == cy_i && ax_i == qx_i && ay_i == qy_i |-> ##4 intersects_o)
    else $error("coincident points reported as disjoint");

endmodule

bind segment_intersection_test seg_chk #(.COORD_WIDTH(COORD_WIDTH)) u_seg_chk (.*);

/* tb/sv/segment_intersection_checker.sv */
`timescale 1ns / 1ps
// Checker for segment_intersection_test: predicts the hit flag of every accepted
// request and compares it with each strobed result, oldest first.
// Needs only the block's port list; shares no code with the design.
module segment_intersection_checker #(
  parameter int unsigned COORD_WIDTH = 30
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  logic signed [COORD_WIDTH-1:0] ax_i,
  input  logic signed [COORD_WIDTH-1:0] ay_i,
  input  logic signed [COORD_WIDTH-1:0] bx_i,
  input  logic signed [COORD_WIDTH-1:0] by_i,
  input  logic signed [COORD_WIDTH-1:0] cx_i,
  input  logic signed [COORD_WIDTH-1:0] cy_i,
  input  logic signed [COORD_WIDTH-1:0] qx_i,
  input  logic signed [COORD_WIDTH-1:0] qy_i,
  input  logic                          done_i,
  input  logic                          intersects_i,
  output int                            err_count_o,
  output int                            pending_o
);

  bit expected_hits [$];

  // z component of (p1 - o) x (p2 - o)
  function automatic longint cross_z(input longint ox, oy, p1x, p1y, p2x, p2y);
    return (p1x - ox) * (p2y - oy) - (p1y - oy) * (p2x - ox);
  endfunction

  function automatic int sign_of(input longint v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  // t on the closed segment s..e
  function automatic bit lies_on(input longint sx, sy, ex, ey, tx, ty);
    if (cross_z(tx, ty, sx, sy, ex, ey) != 0) return 1'b0;
    return ((sx - tx) * (ex - tx) + (sy - ty) * (ey - ty)) <= 0;
  endfunction

  function automatic bit segments_meet(input longint ax, ay, bx, by, cx, cy, dx, dy);
    int side_ab;
    int side_cd;
    side_ab = sign_of(cross_z(ax, ay, bx, by, cx, cy)) *
              sign_of(cross_z(ax, ay, bx, by, dx, dy));
    side_cd = sign_of(cross_z(cx, cy, dx, dy, ax, ay)) *
              sign_of(cross_z(cx, cy, dx, dy, bx, by));
    if (side_ab > 0 || side_cd > 0) return 1'b0;
    if (side_ab == 0 && side_cd == 0)
      return lies_on(ax, ay, bx, by, cx, cy) || lies_on(ax, ay, bx, by, dx, dy) ||
             lies_on(cx, cy, dx, dy, ax, ay) || lies_on(cx, cy, dx, dy, bx, by);
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bit want;
    if (!rst_ni) begin
      expected_hits.delete();
      err_count_o <= 0;
      pending_o   <= 0;
    end else begin
      if (done_i) begin
        if (expected_hits.size() == 0) begin
          $error("intersects: result %0d with no request waiting", intersects_i);
          err_count_o <= err_count_o + 1;
        end else begin
          want = expected_hits.pop_front();
          if (intersects_i !== want) begin
            $error("intersects: expected %0d, actual %0d", want, intersects_i);
            err_count_o <= err_count_o + 1;
          end
        end
      end
      if (start_i && !busy_i)
        expected_hits.push_back(segments_meet(ax_i, ay_i, bx_i, by_i,
                                              cx_i, cy_i, qx_i, qy_i));
      pending_o <= expected_hits.size();
    end
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Top of the segment_intersection_test bench: clock, reset, directed and random
// segment pairs under varying request gaps, and the final verdict.
// Depends on segment_intersection_test and segment_intersection_checker.
module testbench;

  localparam int unsigned COORD_WIDTH = 30;
  localparam longint      CMAX        = (longint'(1) << (COORD_WIDTH - 1)) - 1;
  localparam longint      CMIN        = -(longint'(1) << (COORD_WIDTH - 1));
  localparam int          NUM_RANDOM  = 600;
  localparam int          CYCLE_LIMIT = 200000;

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic signed [COORD_WIDTH-1:0] ax, ay, bx, by, cx, cy, qx, qy;
  logic                          done;
  logic                          intersects;
  int                            fail_count;
  int                            pending;
  int                            idle_pct;
  int                            cycle_count;

  segment_intersection_test #(
    .COORD_WIDTH(COORD_WIDTH)
  ) uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start_i     (start),
    .busy_o      (busy),
    .ax_i        (ax),
    .ay_i        (ay),
    .bx_i        (bx),
    .by_i        (by),
    .cx_i        (cx),
    .cy_i        (cy),
    .qx_i        (qx),
    .qy_i        (qy),
    .done_o      (done),
    .intersects_o(intersects)
  );

  segment_intersection_checker #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start_i     (start),
    .busy_i      (busy),
    .ax_i        (ax),
    .ay_i        (ay),
    .bx_i        (bx),
    .by_i        (by),
    .cx_i        (cx),
    .cy_i        (cy),
    .qx_i        (qx),
    .qy_i        (qy),
    .done_i      (done),
    .intersects_i(intersects),
    .err_count_o (fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench: errors");
    $finish;
  end

  function automatic longint rnd_coord();
    logic signed [COORD_WIDTH-1:0] t;
    t = COORD_WIDTH'($urandom());
    return longint'(t);
  endfunction

  function automatic longint rnd_span(input int lim);
    return longint'(int'($urandom_range(0, 2 * lim)) - lim);
  endfunction

  // drive one request and hold it until accepted, then maybe leave a gap
  task automatic issue(input longint pax, pay, pbx, pby, pcx, pcy, pqx, pqy);
    start <= 1'b1;
    ax <= pax[COORD_WIDTH-1:0];
    ay <= pay[COORD_WIDTH-1:0];
    bx <= pbx[COORD_WIDTH-1:0];
    by <= pby[COORD_WIDTH-1:0];
    cx <= pcx[COORD_WIDTH-1:0];
    cy <= pcy[COORD_WIDTH-1:0];
    qx <= pqx[COORD_WIDTH-1:0];
    qy <= pqy[COORD_WIDTH-1:0];
    @(posedge clk);
    while (busy) @(posedge clk);
    if (int'($urandom_range(0, 99)) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  initial begin
    longint p[8];
    longint bx0, by0, dx0, dy0;
    longint k1, k2, kj, lo, hi;
    int     kind, lim, kmax;
    start    = 1'b0;
    rst_n    = 1'b0;
    idle_pct = 0;
    {ax, ay, bx, by, cx, cy, qx, qy} = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: range corners, crossings, touches, collinear and degenerate pairs
    issue(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
    issue(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
    issue(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN);
    issue(CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX);
    issue(CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX, CMAX);
    issue(CMIN, 0, CMAX, 0, 0, 0, CMAX, 0);
    issue(CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
    issue(0, 0, 10, 0, 0, 1, 10, 1);
    issue(0, 0, 4, 4, 0, 4, 4, 0);
    issue(0, 0, 2, 2, 2, 2, 4, 0);
    issue(0, 0, 4, 0, 2, 0, 2, 5);
    issue(0, 0, 4, 0, 5, -1, 5, 1);
    issue(0, 0, 4, 0, 2, 0, 6, 0);
    issue(0, 0, 2, 0, 3, 0, 5, 0);
    issue(0, 0, 2, 0, 2, 0, 5, 0);
    issue(1, 1, 2, 2, 0, 0, 5, 5);
    issue(0, 0, 5, 5, 1, 1, 2, 2);
    issue(2, 2, 2, 2, 0, 0, 4, 4);
    issue(2, 3, 2, 3, 0, 0, 4, 4);
    issue(5, 5, 5, 5, 0, 0, 4, 4);
    issue(0, 0, 4, 4, 6, 6, 6, 6);
    issue(7, -3, 7, -3, 7, -3, 7, -3);
    issue(7, -3, 7, -3, 7, -2, 7, -2);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      case (i * 4 / NUM_RANDOM)
        0: idle_pct = 0;
        1: idle_pct = 50;
        2: idle_pct = 0;
        default: idle_pct = 23;
      endcase
      kind = $urandom_range(0, 99);
      // points on a common line: base + k * dir
      bx0 = rnd_span(1 << 27);
      by0 = rnd_span(1 << 27);
      lim  = ($urandom_range(0, 1) != 0) ? 4 : (1 << 10);
      kmax = (lim == 4) ? 40 : (1 << 14);
      dx0 = rnd_span(lim);
      dy0 = rnd_span(lim);
      if (kind < 20) begin
        foreach (p[j]) p[j] = rnd_coord();
      end else if (kind < 40) begin
        foreach (p[j]) p[j] = rnd_span(6);
      end else if (kind < 65) begin
        for (int j = 0; j < 4; j++) begin
          kj = rnd_span(kmax);
          p[2*j]   = bx0 + kj * dx0;
          p[2*j+1] = by0 + kj * dy0;
        end
      end else if (kind < 85) begin
        k1 = rnd_span(kmax);
        k2 = rnd_span(kmax);
        lo = (k1 < k2) ? k1 : k2;
        hi = (k1 < k2) ? k2 : k1;
        kj = lo + longint'($urandom_range(0, int'(hi - lo)));
        p[0] = bx0 + k1 * dx0;
        p[1] = by0 + k1 * dy0;
        p[2] = bx0 + k2 * dx0;
        p[3] = by0 + k2 * dy0;
        p[4] = bx0 + kj * dx0;
        p[5] = by0 + kj * dy0;
        if ($urandom_range(0, 1) != 0) begin
          p[6] = bx0 + rnd_span(kmax) * dx0;
          p[7] = by0 + rnd_span(kmax) * dy0;
        end else begin
          p[6] = bx0 + rnd_span(kmax);
          p[7] = by0 + rnd_span(kmax);
        end
      end else begin
        foreach (p[j]) p[j] = rnd_span(6);
        p[2] = p[0];
        p[3] = p[1];
        if ($urandom_range(0, 2) == 0) begin
          p[6] = p[4];
          p[7] = p[5];
        end
      end
      if ($urandom_range(0, 1) != 0)
        issue(p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7]);
      else
        issue(p[4], p[5], p[6], p[7], p[0], p[1], p[2], p[3]);
    end

    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule

/* sim.f */
design/seg_pkg.sv
design/seg_diff.sv
design/seg_mul.sv
design/seg_flag.sv
design/seg_decide.sv
design/segment_intersection_test.sv
design/seg_chk.sv
tb/sv/segment_intersection_checker.sv
tb/sv/testbench.sv
